// File: hw/rtl/hepe_pkg.sv
package hepe_pkg;

    localparam int unsigned DATA_W     = 57;
    localparam int unsigned LEN_W      = 6;
    localparam int unsigned CW_W       = 63;
    localparam int unsigned PCNT_W     = 3;
    localparam int unsigned NUM_PARITY = 6;
    localparam int unsigned MAX_DATA_BITS = 57;

    // XOR tree split: first level in stage 2, last level in stage 3
    localparam int unsigned GRP_W      = 16;
    localparam int unsigned NUM_GRP    = 4;

    typedef struct packed {
        logic [DATA_W-1:0] data_bits;
        logic [LEN_W-1:0]  data_length;
    } hepe_req_t;

    typedef struct packed {
        logic [CW_W-1:0]   codeword;
        logic [PCNT_W-1:0] parity_count;
        logic [LEN_W-1:0]  total_length;
        logic              length_error;
    } hepe_rsp_t;

    // 0-based codeword bit that carries data bit j
    function automatic int unsigned data_pos(input int unsigned j);
        int unsigned cnt;
        int unsigned res;
        cnt = 0;
        res = 0;
        for (int unsigned pos = 1; pos <= CW_W; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                if (cnt == j)
                    res = pos - 1;
                cnt++;
            end
        end
        return res;
    endfunction

    // codeword bits covered by parity bit i
    function automatic logic [GRP_W*NUM_GRP-1:0] cover_mask(input int unsigned i);
        logic [GRP_W*NUM_GRP-1:0] m;
        m = '0;
        for (int unsigned pos = 1; pos <= CW_W; pos++)
        begin
            if (((pos >> i) & 1) != 0)
                m[pos-1] = 1'b1;
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/hamming_even_parity_encoder_core.sv
// Hamming encoder, even parity, variable data length.
//
// Request channel (req_valid/req_ready/req): data_bits plus data_length.
// Response channel (rsp_valid/rsp_ready/rsp): codeword with position 1 at
// bit 0, parity_count, total_length and length_error. Lengths above 57 give
// length_error with all other fields zero.
//
// Three register stages: length decode and data masking, data placement with
// the first XOR level, final parity XOR into the output register. A request
// passes the stage 1, stage 2 and output registers before rsp_valid rises;
// one transfer per cycle is sustained while rsp_ready stays high.
//
// Reset clears all stage valid bits; no response is pending afterwards.
// When the receiver holds rsp_ready low the output register holds its value
// and the stages behind it keep filling bubbles, so up to two more requests are
// taken before req_ready drops. Nothing is lost or repeated under stall.
module hamming_even_parity_encoder_core
    import hepe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  hepe_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output hepe_rsp_t rsp
);

    logic en1, en2, en3;

    logic                 s1_valid_reg;
    logic [DATA_W-1:0]    s1_data_reg, s1_data_next;
    logic [PCNT_W-1:0]    s1_p_reg, s1_p_next;
    logic [LEN_W-1:0]     s1_total_reg, s1_total_next;
    logic                 s1_err_reg, s1_err_next;

    logic                           s2_valid_reg;
    logic [CW_W-1:0]                s2_cw_reg, s2_cw_next;
    logic [NUM_PARITY*NUM_GRP-1:0]  s2_part_reg, s2_part_next;
    logic [PCNT_W-1:0]              s2_p_reg;
    logic [LEN_W-1:0]               s2_total_reg;
    logic                           s2_err_reg;

    logic       rsp_valid_reg;
    hepe_rsp_t  rsp_reg, rsp_next;

    logic [DATA_W-1:0] len_mask;
    logic [GRP_W*NUM_GRP-1:0] cw_ext;

    assign en3 = !rsp_valid_reg || rsp_ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign req_ready = en1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    // stage 1: length decode and masking
    always_comb
    begin
        s1_err_next = (req.data_length > LEN_W'(MAX_DATA_BITS));
        if (req.data_length >= LEN_W'(DATA_W))
            len_mask = '1;
        else
            len_mask = (DATA_W'(1) << req.data_length) - DATA_W'(1);

        priority if (req.data_length == 6'd0)
            s1_p_next = 3'd0;
        else if (req.data_length == 6'd1)
            s1_p_next = 3'd2;
        else if (req.data_length <= 6'd4)
            s1_p_next = 3'd3;
        else if (req.data_length <= 6'd11)
            s1_p_next = 3'd4;
        else if (req.data_length <= 6'd26)
            s1_p_next = 3'd5;
        else
            s1_p_next = 3'd6;

        s1_data_next  = req.data_bits & len_mask;
        s1_total_next = 6'(req.data_length + {3'b000, s1_p_next});
        if (s1_err_next)
        begin
            s1_data_next  = '0;
            s1_p_next     = '0;
            s1_total_next = '0;
        end
    end

    // stage 2: data placement and first XOR level
    for (genvar j = 0; j < DATA_W; j++)
    begin : g_place
        localparam int unsigned POS = data_pos(j);
        assign s2_cw_next[POS] = s1_data_reg[j];
    end

    for (genvar i = 0; i < NUM_PARITY; i++)
    begin : g_pbit
        assign s2_cw_next[(1 << i) - 1] = 1'b0;
    end

    assign cw_ext = {1'b0, s2_cw_next};

    for (genvar i = 0; i < NUM_PARITY; i++)
    begin : g_par
        localparam logic [GRP_W*NUM_GRP-1:0] MASK = cover_mask(i);
        for (genvar g = 0; g < NUM_GRP; g++)
        begin : g_grp
            assign s2_part_next[i*NUM_GRP+g] =
                ^(cw_ext[g*GRP_W +: GRP_W] & MASK[g*GRP_W +: GRP_W]);
        end
    end

    // stage 3: final parity and output register
    always_comb
    begin
        rsp_next.codeword     = s2_cw_reg;
        rsp_next.parity_count = s2_p_reg;
        rsp_next.total_length = s2_total_reg;
        rsp_next.length_error = s2_err_reg;
        for (int i = 0; i < NUM_PARITY; i++)
        begin
            rsp_next.codeword[(1 << i) - 1] = ^s2_part_reg[i*NUM_GRP +: NUM_GRP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= req_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                rsp_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && req_valid)
        begin
            s1_data_reg  <= s1_data_next;
            s1_p_reg     <= s1_p_next;
            s1_total_reg <= s1_total_next;
            s1_err_reg   <= s1_err_next;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_cw_reg    <= s2_cw_next;
            s2_part_reg  <= s2_part_next;
            s2_p_reg     <= s1_p_reg;
            s2_total_reg <= s1_total_reg;
            s2_err_reg   <= s1_err_reg;
        end
        if (en3 && s2_valid_reg)
            rsp_reg <= rsp_next;
    end

endmodule

// File: hw/rtl/hepe_checker.sv
module hepe_checker
    import hepe_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input hepe_rsp_t rsp
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed under stall");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.length_error |->
            rsp.codeword == '0 && rsp.parity_count == '0 && rsp.total_length == '0)
        else $error("error response carries nonzero fields");

    a_cw_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.length_error |-> (rsp.codeword >> rsp.total_length) == '0)
        else $error("codeword bits beyond total length");

    a_pcnt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.length_error && rsp.total_length != '0 |->
            rsp.parity_count >= 3'd2 && rsp.parity_count <= 3'd6)
        else $error("parity count out of range");

endmodule

bind hamming_even_parity_encoder_core hepe_checker u_hepe_checker (.*);
